// ===== design/cgc_pkg.sv =====
package cgc_pkg;

    localparam int unsigned LimitWidth = 8;
    localparam int unsigned GestureWidth = 2;
    localparam logic [LimitWidth-1:0] LimitReset = 8'd25;

    typedef enum logic [2:0] {
        M_IDLE          = 3'd0,
        M_FIRST_PUSH    = 3'd1,
        M_FIRST_RELEASE = 3'd2,
        M_SECOND_PUSH   = 3'd3,
        M_LONG_PUSH     = 3'd4
    } t_mode;

    typedef enum logic [GestureWidth-1:0] {
        G_NONE   = 2'd0,
        G_SINGLE = 2'd1,
        G_DOUBLE = 2'd2,
        G_LONG   = 2'd3
    } t_gesture;

    typedef struct packed {
        logic valid;
        logic pressed;
    } t_sample;

endpackage

// ===== design/cgc_fsm.sv =====
module cgc_fsm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cgc_pkg::t_sample                i_step,
    input  logic [cgc_pkg::LimitWidth-1:0]  i_limit,
    output cgc_pkg::t_gesture               o_gesture
);
    import cgc_pkg::*;

    t_mode                 r_mode;
    t_mode                 n_mode;
    logic [LimitWidth-1:0] r_count;
    logic [LimitWidth-1:0] n_count;
    logic [LimitWidth-1:0] w_count_inc;

    assign w_count_inc = r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_count <= '0;
        end else if (i_step.valid) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        o_gesture = G_NONE;
        unique case (r_mode) inside
            M_IDLE: begin
                if (i_step.pressed) begin
                    n_mode = M_FIRST_PUSH;
                end
            end
            M_FIRST_PUSH, M_SECOND_PUSH: begin
                n_count = w_count_inc;
                if (w_count_inc == i_limit) begin
                    n_count   = '0;
                    n_mode    = M_LONG_PUSH;
                    o_gesture = G_LONG;
                end else if (!i_step.pressed) begin
                    n_count = '0;
                    if (r_mode == M_FIRST_PUSH) begin
                        n_mode = M_FIRST_RELEASE;
                    end else begin
                        n_mode    = M_IDLE;
                        o_gesture = G_DOUBLE;
                    end
                end
            end
            M_FIRST_RELEASE: begin
                if (i_step.pressed) begin
                    n_mode = M_SECOND_PUSH;
                end else begin
                    n_mode    = M_IDLE;
                    o_gesture = G_SINGLE;
                end
            end
            M_LONG_PUSH: begin
                if (!i_step.pressed) begin
                    n_mode = M_IDLE;
                end
            end
            default: begin
                n_mode  = M_IDLE;
                n_count = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_long_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.valid && o_gesture == G_LONG) |=> (r_mode == M_LONG_PUSH && r_count == '0))
        else $error("long press did not enter long push with a cleared count");
    a_count_in_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_mode == M_FIRST_PUSH || r_mode == M_SECOND_PUSH))
        else $error("hold count is nonzero outside a push mode");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_IDLE || r_mode == M_LONG_PUSH) |-> (o_gesture == G_NONE))
        else $error("gesture reported from idle or long push");
`endif

endmodule

// ===== design/click_gesture_classifier.sv =====
// Classifies polled samples of one push button into single clicks, double clicks
// and long presses, returning one gesture code per sample (0 when no gesture ends).
// One sample item is accepted every cycle unless the result side stalls; its result
// passes from the input register into the result register and is held there until
// taken. The input and result registers bound the path, and the gesture state
// machine with its 8-bit hold counter updates once per item between them. The user
// must write the long press limit through i_cfg_we and i_cfg_data while the block
// is idle; the block does not enforce this. It resets to 25; 0 means 256 held samples.
module click_gesture_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_pressed,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [cgc_pkg::GestureWidth-1:0]  o_gesture,
    input  logic                              i_cfg_we,
    input  logic [cgc_pkg::LimitWidth-1:0]    i_cfg_data
);
    import cgc_pkg::*;

    logic                    r_in_valid;
    logic                    r_in_pressed;
    logic                    r_out_valid;
    logic [GestureWidth-1:0] r_gesture;
    logic [LimitWidth-1:0]   r_limit;
    logic                    w_advance;
    t_sample                 w_step;
    t_gesture                w_gesture;

    assign w_advance    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready      = !r_in_valid || w_advance;
    assign w_step       = '{valid: w_advance, pressed: r_in_pressed};
    assign o_valid      = r_out_valid;
    assign o_gesture    = r_gesture;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_pressed <= i_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_gesture <= w_gesture;
        end
    end

    cgc_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_limit   (r_limit),
        .o_gesture (w_gesture)
    );

`ifndef ASSERT_OFF
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_pressed)))
        else $error("buffered input item lost while the result side stalled");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_gesture)))
        else $error("result item changed while the result side stalled");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import cgc_pkg::*;

    class gesture_scoreboard;
        logic [LimitWidth-1:0] limit;
        t_mode                 mode;
        logic [LimitWidth-1:0] hold;
        t_gesture              gesture_q[$];
        int                    errors;

        function new();
            limit  = LimitReset;
            mode   = M_IDLE;
            hold   = '0;
            errors = 0;
        endfunction

        function void set_limit(logic [LimitWidth-1:0] value);
            limit = value;
        endfunction

        function t_gesture count_hold(logic down, t_gesture on_release, t_mode release_mode);
            hold = hold + 1'b1;
            if (hold == limit) begin
                hold = '0;
                mode = M_LONG_PUSH;
                return G_LONG;
            end
            if (!down) begin
                hold = '0;
                mode = release_mode;
                return on_release;
            end
            return G_NONE;
        endfunction

        function void note_sample(logic down);
            t_gesture g;
            g = G_NONE;
            case (mode)
                M_IDLE: begin
                    if (down) mode = M_FIRST_PUSH;
                end
                M_FIRST_PUSH: begin
                    g = count_hold(down, G_NONE, M_FIRST_RELEASE);
                end
                M_FIRST_RELEASE: begin
                    if (!down) begin
                        mode = M_IDLE;
                        g    = G_SINGLE;
                    end else begin
                        mode = M_SECOND_PUSH;
                    end
                end
                M_SECOND_PUSH: begin
                    g = count_hold(down, G_DOUBLE, M_IDLE);
                end
                M_LONG_PUSH: begin
                    if (!down) mode = M_IDLE;
                end
                default: begin
                    mode = M_IDLE;
                    hold = '0;
                end
            endcase
            gesture_q.push_back(g);
        endfunction

        function void check_result(logic [GestureWidth-1:0] got);
            t_gesture want;
            if (gesture_q.size() == 0) begin
                errors++;
                $display("%0t: gesture %0d arrived with none expected", $time, got);
                return;
            end
            want = gesture_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: gesture mismatch, expected %0d, actual %0d", $time, want, got);
            end
        endfunction

        function int outstanding();
            return gesture_q.size();
        endfunction
    endclass

    localparam int CycleLimit = 500000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_pressed;
    logic                    o_valid;
    logic                    i_ready;
    logic [GestureWidth-1:0] o_gesture;
    logic                    i_cfg_we;
    logic [LimitWidth-1:0]   i_cfg_data;

    gesture_scoreboard tracker;
    int                cycles;
    int                sent;
    bit                send_calm;
    bit                take_calm;

    click_gesture_classifier u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pressed  (i_pressed),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_gesture  (o_gesture),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_sample(input logic down);
        int gap;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pressed <= down;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.note_sample(down);
        sent++;
    endtask

    task automatic hold_button(input int n, input logic down);
        repeat (n) send_sample(down);
    endtask

    task automatic write_limit(input logic [LimitWidth-1:0] value);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.outstanding() > 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_limit(value);
    endtask

    task automatic play_gesture(input int reach);
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            hold_button(n, 1'b1);
            hold_button($urandom_range(2, 4), 1'b0);
        end else if (pick < 60) begin
            hold_button($urandom_range(1, 6), 1'b1);
            send_sample(1'b0);
            hold_button($urandom_range(1, 6), 1'b1);
            hold_button($urandom_range(1, 3), 1'b0);
        end else if (pick < 72 && reach <= 64) begin
            hold_button(reach + $urandom_range(0, 4), 1'b1);
            hold_button($urandom_range(1, 2), 1'b0);
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) send_sample(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(input logic [LimitWidth-1:0] value, input int quota);
        int start;
        int reach;
        write_limit(value);
        reach = (value == 0) ? 256 : int'(value);
        start = sent;
        while (sent - start < quota) play_gesture(reach);
        if (reach > 64) begin
            hold_button(reach + 2, 1'b1);
            hold_button(2, 1'b0);
        end
    endtask

    initial begin
        int take_wait;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
            take_wait = take_calm ? 0 : $urandom_range(0, 12);
            @(negedge i_clk);
            if (take_wait > 0) begin
                i_ready <= 1'b0;
                repeat (take_wait) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            tracker.check_result(o_gesture);
        end
    end

    initial begin
        tracker    = new();
        cycles     = 0;
        sent       = 0;
        send_calm  = 1'b0;
        take_calm  = 1'b0;
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_pressed  = 1'b0;
        i_ready    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single and double clicks at the reset limit, then two quiet samples.
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b0);
        send_sample(1'b0);

        // Long press from the first push and from the second push.
        write_limit(8'd2);
        hold_button(4, 1'b1);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
        hold_button(3, 1'b1);
        send_sample(1'b0);
        send_sample(1'b0);

        run_phase(8'd1, 40);
        run_phase(8'd255, 40);
        run_phase(8'd0, 40);
        run_phase(8'd30, 80);
        run_phase(8'($urandom_range(3, 40)), 80);
        run_phase(LimitReset, 70);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.outstanding() > 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
